@@ src/pgw_pkg.sv @@
package pgw_pkg;

  localparam int ADDR_W  = 52;
  localparam int VA_W    = 48;
  localparam int ENTRY_W = 64;
  localparam int IDX_W   = 9;

  // 8-byte entries: index scaled by a 3-bit shift
  localparam int ENTRY_SHIFT = 3;

  // stream packing
  localparam int ROOT_LSB   = 0;
  localparam int VA_LSB     = ADDR_W;
  localparam int ENTRY_LSB  = ADDR_W + VA_W;
  localparam int IN_DATA_W  = ((ADDR_W + VA_W + ENTRY_W + 7) / 8) * 8;
  localparam int OUT_USED_W = ADDR_W + ADDR_W + 2;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  typedef enum logic {
    ITEM_REQ = 1'b0,
    ITEM_RSP = 1'b1
  } item_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SIZE_4K = 2'd0,
    SIZE_2M = 2'd1,
    SIZE_1G = 2'd2
  } size_t;

  // classified item handed from front to back
  typedef struct packed {
    item_t               item;
    logic [VA_W-1:0]     va;
    logic [ADDR_W-1:0]   read_addr;  // first-level entry address (requests)
    logic                addr_zero;
    logic [ENTRY_W-1:0]  entry;
  } work_t;

  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  read_address;
    logic [ADDR_W-1:0]  phys_addr;
    size_t              map_size;
  } result_t;

  function automatic logic [IDX_W-1:0] level_index(logic [VA_W-1:0] va, logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      LVL_PT:   idx = va[20:12];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

@@ src/pgw_front.sv @@
module pgw_front #(
  parameter int PHYS_ADDR_BITS = 52
) (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic                           s_tuser,
  input  logic [pgw_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           q_full,
  output logic                           push,
  output pgw_pkg::work_t                 work
);

  logic [pgw_pkg::ADDR_W-1:0]  root;
  logic [pgw_pkg::VA_W-1:0]    va;
  logic [PHYS_ADDR_BITS-1:0]   first_addr;

  assign root = s_tdata[pgw_pkg::ROOT_LSB +: pgw_pkg::ADDR_W];
  assign va   = s_tdata[pgw_pkg::VA_LSB +: pgw_pkg::VA_W];

  // PML4 entry address; root bits above the physical width drop out
  assign first_addr = root[PHYS_ADDR_BITS-1:0] + PHYS_ADDR_BITS'({
    pgw_pkg::level_index(va, pgw_pkg::LVL_PML4), {pgw_pkg::ENTRY_SHIFT{1'b0}}});

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    work.item      = pgw_pkg::item_t'(s_tuser);
    work.va        = va;
    work.read_addr = pgw_pkg::ADDR_W'(first_addr);
    work.addr_zero = (first_addr == '0);
    work.entry     = s_tdata[pgw_pkg::ENTRY_LSB +: pgw_pkg::ENTRY_W];
  end

endmodule

@@ src/pgw_queue.sv @@
module pgw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pgw_pkg::work_t  wdata,
  input  logic            pop,
  output logic            full,
  output logic            valid,
  output pgw_pkg::work_t  rdata
);

  pgw_pkg::work_t                  mem [pgw_pkg::QUEUE_DEPTH];
  logic [pgw_pkg::PTR_W-1:0]       wr_ptr;
  logic [pgw_pkg::PTR_W-1:0]       rd_ptr;
  logic [pgw_pkg::CNT_W-1:0]       count;

  function automatic logic [pgw_pkg::PTR_W-1:0] ptr_inc(logic [pgw_pkg::PTR_W-1:0] p);
    return (p == pgw_pkg::PTR_W'(pgw_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count == pgw_pkg::CNT_W'(pgw_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + pgw_pkg::CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - pgw_pkg::CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pgw_pkg::CNT_W'(pgw_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + pgw_pkg::CNT_W'(1))
    else $error("queue count did not follow push");

endmodule

@@ src/pgw_back.sv @@
module pgw_back #(
  parameter int PHYS_ADDR_BITS = 52
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  pgw_pkg::work_t    work,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output pgw_pkg::result_t  result
);

  logic                        busy;
  logic                        busy_next;
  logic [1:0]                  level;
  logic [1:0]                  level_next;
  logic [pgw_pkg::VA_W-1:0]    saved_address;
  logic [pgw_pkg::VA_W-1:0]    saved_address_next;
  logic                        res_valid;
  pgw_pkg::result_t            res;
  logic                        advance;
  logic [1:0]                  lvl_inc;
  logic [PHYS_ADDR_BITS-1:0]   frame12;
  logic [PHYS_ADDR_BITS-1:0]   step_addr;
  logic                        big_page;

  assign advance = !m_tvalid || m_tready;
  assign pop     = q_valid && advance;

  assign lvl_inc   = level + 2'd1;
  assign frame12   = {work.entry[PHYS_ADDR_BITS-1:12], 12'b0};
  assign step_addr = frame12 + PHYS_ADDR_BITS'({
    pgw_pkg::level_index(saved_address, lvl_inc), {pgw_pkg::ENTRY_SHIFT{1'b0}}});
  assign big_page  = work.entry[pgw_pkg::BIT_LARGE];

  always_comb begin
    busy_next          = busy;
    level_next         = level;
    saved_address_next = saved_address;
    res_valid          = 1'b0;
    res.kind             = pgw_pkg::KIND_FAULT;
    res.read_address     = '0;
    res.phys_addr        = '0;
    res.map_size         = pgw_pkg::SIZE_4K;
    if (work.item == pgw_pkg::ITEM_REQ) begin
      // a new request always restarts the walk
      saved_address_next = work.va;
      res_valid          = 1'b1;
      level_next         = pgw_pkg::LVL_PML4;
      if (work.addr_zero) begin
        busy_next = 1'b0;
      end else begin
        busy_next        = 1'b1;
        res.kind         = pgw_pkg::KIND_READ;
        res.read_address = work.read_addr;
      end
    end else if (busy) begin
      res_valid  = 1'b1;
      busy_next  = 1'b0;
      level_next = pgw_pkg::LVL_PML4;
      if (!work.entry[pgw_pkg::BIT_PRESENT]) begin
        res.kind = pgw_pkg::KIND_FAULT;
      end else if (level == pgw_pkg::LVL_PDPT && big_page) begin
        res.kind      = pgw_pkg::KIND_DONE;
        res.map_size  = pgw_pkg::SIZE_1G;
        res.phys_addr = pgw_pkg::ADDR_W'(
          {work.entry[PHYS_ADDR_BITS-1:30], saved_address[29:0]});
      end else if (level == pgw_pkg::LVL_PD && big_page) begin
        res.kind      = pgw_pkg::KIND_DONE;
        res.map_size  = pgw_pkg::SIZE_2M;
        res.phys_addr = pgw_pkg::ADDR_W'(
          {work.entry[PHYS_ADDR_BITS-1:21], saved_address[20:0]});
      end else if (level == pgw_pkg::LVL_PT) begin
        res.kind      = pgw_pkg::KIND_DONE;
        res.map_size  = pgw_pkg::SIZE_4K;
        res.phys_addr = pgw_pkg::ADDR_W'(
          {work.entry[PHYS_ADDR_BITS-1:12], saved_address[11:0]});
      end else if (step_addr != '0) begin
        busy_next        = 1'b1;
        level_next       = lvl_inc;
        res.kind         = pgw_pkg::KIND_READ;
        res.read_address = pgw_pkg::ADDR_W'(step_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      level    <= pgw_pkg::LVL_PML4;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        busy  <= busy_next;
        level <= level_next;
      end
      if (advance) begin
        m_tvalid <= pop && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      saved_address <= saved_address_next;
    end
    if (pop && res_valid) begin
      result <= res;
    end
  end

  a_idle_level: assert property (@(posedge clk) disable iff (rst)
    !busy |-> level == pgw_pkg::LVL_PML4)
    else $error("idle walker with nonzero level");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    pop && res_valid && res.kind == pgw_pkg::KIND_READ |=> busy)
    else $error("read issued but walker not busy");

  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !pop)
    else $error("queue popped while output stalled");

endmodule

@@ src/four_level_page_table_walker_top.sv @@
// An accepted input transaction passes the queue write and then the output register, which
// raises m_tvalid. Throughput: one transaction per cycle while the sink takes results;
// each item is a single pass through the back end.
// The front end stalls only when the two-entry queue is full, i.e. when the output is
// held by the sink. Responses arriving while idle are consumed with no result.
// Reset (rst, synchronous): walker idle, queue empty, no result valid.
module four_level_page_table_walker_top #(
  parameter int PHYS_ADDR_BITS = 52
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic                            s_tuser,   // req_type
  // table_root[51:0], lin_addr[99:52], entry_data[163:100], zero pad
  input  logic [pgw_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [1:0]                      m_tuser,   // result_kind
  // read_address[51:0], phys_addr[103:52], map_size[105:104], zero pad
  output logic [pgw_pkg::OUT_DATA_W-1:0]  m_tdata
);

  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_valid;
  pgw_pkg::work_t    front_work;
  pgw_pkg::work_t    back_work;
  pgw_pkg::result_t  result;

  pgw_front #(
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .work     (front_work)
  );

  pgw_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_work),
    .pop   (pop),
    .full  (q_full),
    .valid (q_valid),
    .rdata (back_work)
  );

  pgw_back #(
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .work     (back_work),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .result   (result)
  );

  assign m_tuser = result.kind;
  assign m_tdata = {{pgw_pkg::OUT_PAD_W{1'b0}}, result.map_size,
                    result.phys_addr, result.read_address};

endmodule
